### design/qrm_pkg.sv
package qrm_pkg;

  // Matrix entries are signed Q1.14.
  localparam int FRAC_BITS = 14;
  localparam int MAT_W     = 16;
  localparam logic [MAT_W-1:0] ONE_Q = MAT_W'(1 << FRAC_BITS);

  // Quotient bits produced by the divider lane, one per stage.
  localparam int QBITS   = FRAC_BITS + 1;
  // Divider lane depth: one stage per quotient bit plus the rounding stage.
  localparam int DIV_LAT = QBITS + 1;

  // Number of matrix entries.
  localparam int NUM_ENT = 9;

  typedef logic signed [MAT_W-1:0] mat_t;

endpackage

### design/qrm_div_lane.sv
// One matrix entry: round(a * 2^14 / d) with ties away from zero, computed as
// a restoring division of a * 2^15 by 2d, one quotient bit per stage, and a
// final stage that adds the rounding bit, saturates and applies the sign.
module qrm_div_lane
  import qrm_pkg::*;
#(
  parameter int COMP_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COMP_WIDTH-1:0] a_i,
  input  logic [COMP_WIDTH-1:0] d_i,
  input  logic                  neg_i,
  output mat_t                  m_o
);

  localparam int RW = COMP_WIDTH + 1;

  logic [RW-1:0]         r_r   [QBITS];
  logic [QBITS-1:0]      q_r   [QBITS];
  logic [COMP_WIDTH-1:0] d_r   [QBITS];
  logic                  neg_r [QBITS];
  mat_t                  m_r;

  // Division stages; the remainder always stays below 2d.
  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [RW-1:0]         rin;
    logic [QBITS-1:0]      qin;
    logic [COMP_WIDTH-1:0] din;
    logic                  nin;
    logic [RW:0]           r2;
    logic [RW:0]           dd;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rin = {1'b0, a_i};
      assign qin = '0;
      assign din = d_i;
      assign nin = neg_i;
    end else begin : g_next
      assign rin = r_r[k-1];
      assign qin = q_r[k-1];
      assign din = d_r[k-1];
      assign nin = neg_r[k-1];
    end

    assign r2 = {rin, 1'b0};
    assign dd = {1'b0, din, 1'b0};
    assign ge = (r2 >= dd);

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= ge ? RW'(r2 - dd) : RW'(r2);
        q_r[k]   <= {qin[QBITS-2:0], ge};
        d_r[k]   <= din;
        neg_r[k] <= nin;
      end
    end
  end

  // Rounding, saturation to one and sign.
  logic             rnd;
  logic [MAT_W-1:0] qsum;
  logic [MAT_W-1:0] qsat;

  always_comb begin
    rnd  = (r_r[QBITS-1] >= {1'b0, d_r[QBITS-1]});
    qsum = MAT_W'(q_r[QBITS-1]) + MAT_W'(rnd);
    qsat = (qsum > ONE_Q) ? ONE_Q : qsum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= neg_r[QBITS-1] ? mat_t'(-qsat) : mat_t'(qsat);
    end
  end

  assign m_o = m_r;

endmodule

### design/quaternion_to_rotation_matrix_top.sv
// Quaternion to 3x3 rotation matrix. Each item is one quaternion (w, x, y, z)
// in signed Q1.14; the result item is the rotation matrix of the normalized
// quaternion in signed Q1.14, each entry rounded to nearest and held within
// plus or minus one. No square root is taken: every entry is a numerator of
// exact products divided by the squared norm, after both are scaled down so
// the norm fits COMP_WIDTH bits. An all-zero quaternion gives a zero matrix
// with the zero_error flag set in out_tuser. The pipeline takes one item every
// cycle and passes it through five stages of products, sums and scaling,
// then 16 stages of the nine divider lanes, 15 of them producing one
// quotient bit each and a last one for rounding, saturation and sign.
// A stall on the output side holds the whole pipeline.
module quaternion_to_rotation_matrix_top
  import qrm_pkg::*;
#(
  parameter int COMP_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         out_tuser   // zero_error
);

  localparam int SW = $clog2(34 - COMP_WIDTH);

  logic en;

  // Stage 1: input registers.
  logic signed [15:0] w_r, x_r, y_r, z_r;
  logic               vld1_r;

  // Stage 2: products.
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, xw_r, yz_r, yw_r, zw_r;
  logic               vld2_r;

  // Stage 3: norm and numerators.
  logic [32:0]        n3_r;
  logic signed [33:0] num3_r [NUM_ENT];
  logic               vld3_r;

  // Stage 4: magnitudes and scale shift.
  logic [32:0]        mag4_r [NUM_ENT];
  logic               neg4_r [NUM_ENT];
  logic [32:0]        n4_r;
  logic [SW-1:0]      s4_r;
  logic               zero4_r;
  logic               vld4_r;

  // Stage 5: scaled divider operands.
  logic [COMP_WIDTH-1:0] a5_r [NUM_ENT];
  logic                  neg5_r [NUM_ENT];
  logic [COMP_WIDTH-1:0] d5_r;
  logic                  zero5_r;
  logic                  vld5_r;

  // Flags that travel beside the divider lanes.
  logic vpipe_r [DIV_LAT];
  logic zpipe_r [DIV_LAT];

  mat_t m_ent [NUM_ENT];

  // The pipeline moves unless a finished item waits on the output.
  assign en        = !(vpipe_r[DIV_LAT-1] && !out_tready);
  assign in_tready = en;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vpipe_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld1_r     <= in_tvalid;
      vld2_r     <= vld1_r;
      vld3_r     <= vld2_r;
      vld4_r     <= vld3_r;
      vld5_r     <= vld4_r;
      vpipe_r[0] <= vld5_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vpipe_r[i] <= vpipe_r[i-1];
      end
    end
  end

  // Stages 1 and 2: capture and multiply.
  always_ff @(posedge clk) begin
    if (en) begin
      w_r  <= in_tdata[15:0];
      x_r  <= in_tdata[31:16];
      y_r  <= in_tdata[47:32];
      z_r  <= in_tdata[63:48];
      ww_r <= w_r * w_r;
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      zz_r <= z_r * z_r;
      xy_r <= x_r * y_r;
      xz_r <= x_r * z_r;
      xw_r <= x_r * w_r;
      yz_r <= y_r * z_r;
      yw_r <= y_r * w_r;
      zw_r <= z_r * w_r;
    end
  end

  // Stage 3: squared norm and the nine numerators.
  logic signed [33:0] sq_w, sq_x, sq_y, sq_z;
  logic signed [33:0] p_xy, p_xz, p_xw, p_yz, p_yw, p_zw;

  always_comb begin
    sq_w = 34'(ww_r);
    sq_x = 34'(xx_r);
    sq_y = 34'(yy_r);
    sq_z = 34'(zz_r);
    p_xy = 34'(xy_r);
    p_xz = 34'(xz_r);
    p_xw = 34'(xw_r);
    p_yz = 34'(yz_r);
    p_yw = 34'(yw_r);
    p_zw = 34'(zw_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r      <= 33'(sq_w + sq_x + sq_y + sq_z);
      num3_r[0] <= sq_w + sq_x - sq_y - sq_z;
      num3_r[1] <= (p_xy - p_zw) <<< 1;
      num3_r[2] <= (p_xz + p_yw) <<< 1;
      num3_r[3] <= (p_xy + p_zw) <<< 1;
      num3_r[4] <= sq_w - sq_x + sq_y - sq_z;
      num3_r[5] <= (p_yz - p_xw) <<< 1;
      num3_r[6] <= (p_xz - p_yw) <<< 1;
      num3_r[7] <= (p_yz + p_xw) <<< 1;
      num3_r[8] <= sq_w - sq_x - sq_y + sq_z;
    end
  end

  // Stage 4: smallest shift that brings the norm below 2^COMP_WIDTH.
  logic [SW-1:0] s_nxt;

  always_comb begin
    s_nxt = '0;
    for (int i = 0; i < 33; i++) begin
      if (i >= COMP_WIDTH && n3_r[i]) begin
        s_nxt = SW'(i - COMP_WIDTH + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        neg4_r[e] <= num3_r[e][33];
        mag4_r[e] <= num3_r[e][33] ? 33'(-num3_r[e]) : 33'(num3_r[e]);
      end
      n4_r    <= n3_r;
      s4_r    <= s_nxt;
      zero4_r <= (n3_r == '0);
    end
  end

  // Stage 5: scale numerators and norm alike.
  logic [32:0] a_sh [NUM_ENT];
  logic [32:0] d_sh;

  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      a_sh[e] = mag4_r[e] >> s4_r;
    end
    d_sh = n4_r >> s4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        a5_r[e]   <= a_sh[e][COMP_WIDTH-1:0];
        neg5_r[e] <= neg4_r[e];
      end
      d5_r    <= d_sh[COMP_WIDTH-1:0];
      zero5_r <= zero4_r;
    end
  end

  // Zero flag delay matching the divider lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      zpipe_r[0] <= zero5_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        zpipe_r[i] <= zpipe_r[i-1];
      end
    end
  end

  // Nine divider lanes, one per matrix entry.
  for (genvar e = 0; e < NUM_ENT; e++) begin : g_lane
    qrm_div_lane #(
      .COMP_WIDTH(COMP_WIDTH)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .a_i   (a5_r[e]),
      .d_i   (d5_r),
      .neg_i (neg5_r[e]),
      .m_o   (m_ent[e])
    );
  end

  // Output; a zero quaternion forces the matrix to zero.
  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      out_tdata[e*MAT_W +: MAT_W] = zpipe_r[DIV_LAT-1] ? '0 : m_ent[e];
    end
  end

  assign out_tvalid = vpipe_r[DIV_LAT-1];
  assign out_tuser  = zpipe_r[DIV_LAT-1];

endmodule

### design/qrm_checker.sv
// Port-level checks for the quaternion to rotation matrix block.
module qrm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tuser
);

  // A waiting result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // An output stall stops intake.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken during output stall");

  // A zero quaternion yields a zero matrix.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero quaternion gave nonzero matrix");

  // Diagonal entries stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384)
                && ($signed(out_tdata[15:0]) >= -16'sd16384)
                && ($signed(out_tdata[79:64]) <= 16'sd16384)
                && ($signed(out_tdata[79:64]) >= -16'sd16384)
                && ($signed(out_tdata[143:128]) <= 16'sd16384)
                && ($signed(out_tdata[143:128]) >= -16'sd16384))
    else $error("matrix entry out of range");

endmodule

bind quaternion_to_rotation_matrix_top qrm_checker u_qrm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
